/* rtl/metr_pkg.sv */
// shared types and constants for the manchester edge timing receiver
// no dependencies
package metr_pkg;

  localparam int STATUS_W = 3;
  localparam int BP_W     = 15;
  localparam int TO_W     = 16;
  localparam int THR_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int FRAME_W  = 16;
  localparam int CFG_W    = 16;
  localparam int ADDR_W   = 2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LONG    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd4;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [ADDR_W-1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_INVERT     = 2'd2;

  // input kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ARM  = 1'b1;

  localparam logic [BP_W-1:0]  BIT_PERIOD_RST = 15'd1000;
  localparam logic [TO_W-1:0]  TIMEOUT_RST    = 16'd2000;
  localparam logic [THR_W-1:0] LO_RST         = 16'd333;
  localparam logic [THR_W-1:0] MID_RST        = 16'd666;
  localparam logic [THR_W-1:0] HI_RST         = 16'd1333;

  localparam int FIRST_BYTE_AT = 9;

  // x / 3 for x below 2**17 as (x * ceil(2**18 / 3)) >> 18
  localparam int          DIV_IN_W  = 17;
  localparam int          RECIP_SH  = 18;
  localparam int          PROD_W    = 35;
  localparam logic [17:0] RECIP3    = 18'd87382;

  typedef struct packed {
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] mid;
    logic [THR_W-1:0] hi;
  } thr_t;

  function automatic logic [THR_W-1:0] div3(input logic [DIV_IN_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(RECIP3);
    return prod[RECIP_SH +: THR_W];
  endfunction

  function automatic thr_t thresholds(input logic [BP_W-1:0] p);
    thr_t t;
    t.lo  = div3(DIV_IN_W'(p));
    t.mid = div3({1'b0, p, 1'b0});
    t.hi  = div3({p, 2'b00});
    return t;
  endfunction

endpackage

/* rtl/manchester_edge_timing_receiver_unit.sv */
// manchester edge timing receiver, top level
// depends on metr_pkg
//
// usage
//   input stream: one word per tick; in_tuser is the kind (0 line sample,
//   1 arm and clear status), in_tdata[0] is the sampled line level
//   result stream: one word for every input word, carrying status,
//   receiving flag and the received frame (zero unless status is frame ok)
//   config port: cfg_we writes cfg_wdata into the register at cfg_addr
//   (0 bit period, 1 timeout ticks, 2 line invert); the edge windows are
//   derived from the bit period in the write cycle
// timing
//   the result word is registered on acceptance and shown in the cycle after
//   it; one word is accepted every cycle while the result side takes words,
//   set by the single state update stage feeding the result register
// reset
//   rst_n low clears all receive state, loads register defaults (bit period
//   1000, timeout 2000, no invert) and empties the result register
// stall
//   when out_tready is low the result word holds and in_tready drops until
//   the word is taken
module manchester_edge_timing_receiver_unit
  import metr_pkg::*;
#(
  parameter int FRAME_BITS  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // line
  input  logic                in_tuser,   // kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // status[2:0], receiving, frame_data
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int BC_W  = $clog2((FRAME_BITS > 8 ? FRAME_BITS : 8) + 2);
  localparam int CMP_W = COUNT_WIDTH > THR_W ? COUNT_WIDTH : THR_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [TO_W-1:0]        timeout_r;
  logic                   invert_r;
  thr_t                   thr_r;

  logic [COUNT_WIDTH-1:0] gap_r, gap_nxt, gap_inc;
  logic                   counting_r, counting_nxt;
  logic                   armed_r, armed_nxt;
  logic [BC_W-1:0]        bit_count_r, bit_count_nxt;
  logic                   expect_full_r, expect_full_nxt;
  logic [BYTE_W-1:0]      shift_r, shift_nxt;
  logic [BYTE_W-1:0]      first_r, first_nxt;
  logic                   last_line_r, last_line_nxt;
  logic [STATUS_W-1:0]    code_r, code_nxt;

  logic                   out_valid_r;
  logic [23:0]            out_data_r;

  logic                   accept;
  logic                   level;
  logic                   edge_seen;
  logic                   take;
  logic [CMP_W-1:0]       gap_c, lo_c, mid_c, hi_c, to_c;
  logic [FRAME_W-1:0]     frame;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      invert_r  <= 1'b0;
      thr_r     <= '{lo: LO_RST, mid: MID_RST, hi: HI_RST};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BIT_PERIOD: thr_r     <= thresholds(cfg_wdata[BP_W-1:0]);
        REG_TIMEOUT:    timeout_r <= cfg_wdata[TO_W-1:0];
        REG_INVERT:     invert_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign level     = in_tdata[0] ^ invert_r;
  assign edge_seen = level != last_line_r;
  assign gap_inc   = gap_r + COUNT_WIDTH'(gap_r != COUNT_MAX);
  assign gap_c     = CMP_W'(gap_inc);
  assign lo_c      = CMP_W'(thr_r.lo);
  assign mid_c     = CMP_W'(thr_r.mid);
  assign hi_c      = CMP_W'(thr_r.hi);
  assign to_c      = CMP_W'(timeout_r);

  always_comb begin
    gap_nxt         = gap_r;
    counting_nxt    = counting_r;
    armed_nxt       = armed_r;
    bit_count_nxt   = bit_count_r;
    expect_full_nxt = expect_full_r;
    shift_nxt       = shift_r;
    first_nxt       = first_r;
    last_line_nxt   = level;
    code_nxt        = code_r;
    take            = 1'b0;
    if (in_tuser == KIND_ARM) begin
      armed_nxt       = 1'b1;
      counting_nxt    = 1'b0;
      gap_nxt         = '0;
      bit_count_nxt   = '0;
      expect_full_nxt = 1'b0;
      code_nxt        = ST_BUSY;
    end else if (armed_r) begin
      if (!counting_r) begin
        if (edge_seen && !level) begin
          counting_nxt    = 1'b1;
          gap_nxt         = '0;
          expect_full_nxt = 1'b0;
          bit_count_nxt   = BC_W'(1);
        end
      end else if (edge_seen) begin
        gap_nxt = '0;
        priority if (lo_c < gap_c && gap_c < mid_c) begin
          expect_full_nxt = !expect_full_r;
          take            = !expect_full_r;
        end else if (mid_c < gap_c && gap_c < hi_c) begin
          if (expect_full_r) begin
            take = 1'b1;
          end else begin
            armed_nxt    = 1'b0;
            counting_nxt = 1'b0;
            code_nxt     = ST_LONG;
          end
        end else begin
          armed_nxt    = 1'b0;
          counting_nxt = 1'b0;
          code_nxt     = ST_BAD;
        end
      end else begin
        gap_nxt = gap_inc;
        if (gap_c >= to_c) begin
          armed_nxt    = 1'b0;
          counting_nxt = 1'b0;
          code_nxt     = ST_TIMEOUT;
        end
      end
    end
    if (take) begin
      shift_nxt     = {shift_r[BYTE_W-2:0], level};
      bit_count_nxt = bit_count_r + BC_W'(1);
      if (bit_count_nxt == BC_W'(FIRST_BYTE_AT)) begin
        first_nxt = shift_nxt;
      end
      if (bit_count_nxt == BC_W'(FRAME_BITS + 1)) begin
        armed_nxt    = 1'b0;
        counting_nxt = 1'b0;
        code_nxt     = ST_OK;
      end
    end
  end

  assign frame = (code_nxt == ST_OK) ? {first_nxt, shift_nxt} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r         <= '0;
      counting_r    <= 1'b0;
      armed_r       <= 1'b0;
      bit_count_r   <= '0;
      expect_full_r <= 1'b0;
      shift_r       <= '0;
      first_r       <= '0;
      last_line_r   <= 1'b0;
      code_r        <= ST_BUSY;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        gap_r         <= gap_nxt;
        counting_r    <= counting_nxt;
        armed_r       <= armed_nxt;
        bit_count_r   <= bit_count_nxt;
        expect_full_r <= expect_full_nxt;
        shift_r       <= shift_nxt;
        first_r       <= first_nxt;
        last_line_r   <= last_line_nxt;
        code_r        <= code_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {4'b0000, frame, armed_nxt, code_nxt};
    end
  end

endmodule

/* rtl/metr_checker.sv */
// port level checks for the manchester edge timing receiver
// depends on metr_pkg; bound to manchester_edge_timing_receiver_unit
module metr_checker
  import metr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // frame only shown with a good status
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[19:4] == '0)
    else $error("frame data set without frame ok");

  // a final status means reception stopped
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_BUSY |-> !out_tdata[3])
    else $error("receiving while a final status is shown");

  // arm word gives a busy, receiving result next cycle
  a_arm_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_ARM |=>
      out_tvalid && out_tdata[3] && out_tdata[2:0] == ST_BUSY)
    else $error("arm word did not give an armed result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_TIMEOUT)
    else $error("status out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

endmodule

bind manchester_edge_timing_receiver_unit metr_checker u_metr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/manchester_edge_timing_receiver_unit_tb.sv */
// testbench for manchester_edge_timing_receiver_unit: drives line samples and arm words,
// predicts every result word with its own receiver model and checks it field by field
// depends on metr_pkg and the rtl top level
`timescale 1ns / 1ps

import metr_pkg::*;

class edge_timing_scoreboard;
  localparam int FRAME_LEN = 16;
  localparam int COUNT_MAX = (1 << 16) - 1;

  logic [BP_W-1:0]     period;
  logic [TO_W-1:0]     tmo;
  logic                inv;
  int                  gap_cnt;
  bit                  counting;
  bit                  armed;
  bit                  exp_full;
  int                  nbits;
  logic [BYTE_W-1:0]   shreg;
  logic [BYTE_W-1:0]   hi_byte;
  logic                line_q;
  logic [STATUS_W-1:0] code;
  logic [23:0]         expected_words[$];
  int                  mismatches;

  function new();
    period = BIT_PERIOD_RST;
    tmo = TIMEOUT_RST;
    inv = 1'b0;
    gap_cnt = 0;
    counting = 0;
    armed = 0;
    exp_full = 0;
    nbits = 0;
    shreg = '0;
    hi_byte = '0;
    line_q = 1'b0;
    code = ST_BUSY;
    mismatches = 0;
  endfunction

  function void write_reg(logic [ADDR_W-1:0] a, logic [CFG_W-1:0] v);
    case (a)
      REG_BIT_PERIOD: period = v[BP_W-1:0];
      REG_TIMEOUT:    tmo = v[TO_W-1:0];
      REG_INVERT:     inv = v[0];
      default: ;
    endcase
  endfunction

  function void halt(logic [STATUS_W-1:0] c);
    armed = 0;
    counting = 0;
    code = c;
  endfunction

  function void shift_in(logic lvl);
    shreg = {shreg[BYTE_W-2:0], lvl};
    nbits++;
    if (nbits == FIRST_BYTE_AT) hi_byte = shreg;
    if (nbits == FRAME_LEN + 1) halt(ST_OK);
  endfunction

  function void classify(int g, logic lvl);
    int p;
    int lo;
    int mid;
    int hi;
    p = period;
    lo = p / 3;
    mid = (p * 2) / 3;
    hi = (p * 4) / 3;
    if (g > lo && g < mid) begin
      if (exp_full) begin
        exp_full = 0;
      end else begin
        exp_full = 1;
        shift_in(lvl);
      end
    end else if (g > mid && g < hi) begin
      if (exp_full) shift_in(lvl);
      else halt(ST_LONG);
    end else begin
      halt(ST_BAD);
    end
  endfunction

  function void note_word(logic k, logic l);
    logic lvl;
    bit   edge_seen;
    int   g;
    lvl = l ^ inv;
    if (k == KIND_ARM) begin
      armed = 1;
      counting = 0;
      gap_cnt = 0;
      nbits = 0;
      exp_full = 0;
      code = ST_BUSY;
      line_q = lvl;
    end else begin
      edge_seen = (lvl != line_q);
      line_q = lvl;
      if (armed) begin
        if (!counting) begin
          if (edge_seen && lvl == 1'b0) begin
            counting = 1;
            gap_cnt = 0;
            exp_full = 0;
            nbits = 1;
          end
        end else begin
          g = gap_cnt;
          if (g < COUNT_MAX) g++;
          if (edge_seen) begin
            gap_cnt = 0;
            classify(g, lvl);
          end else begin
            gap_cnt = g;
            if (g >= int'(tmo)) halt(ST_TIMEOUT);
          end
        end
      end
    end
    expected_words.push_back({4'b0, (code == ST_OK) ? {hi_byte, shreg} : 16'h0, armed, code});
  endfunction

  function void check_word(logic [23:0] w);
    logic [23:0] e;
    if (expected_words.size() == 0) begin
      if (mismatches < 10) $display("unexpected result word %h", w);
      mismatches++;
      return;
    end
    e = expected_words.pop_front();
    if (w[2:0] !== e[2:0] || w[3] !== e[3] || w[19:4] !== e[19:4]) begin
      if (mismatches < 10)
        $display("mismatch: expected status %0d rx %0d frame %h, got status %0d rx %0d frame %h",
                 e[2:0], e[3], e[19:4], w[2:0], w[3], w[19:4]);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module manchester_edge_timing_receiver_unit_tb;
  localparam int FRAME_BITS  = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS       = 850;

  localparam int MODE_RX_SLOW = 0;
  localparam int MODE_TX_SLOW = 1;
  localparam int MODE_NO_IDLE = 2;

  localparam int FLAW_NONE  = 0;
  localparam int FLAW_GAP   = 1;
  localparam int FLAW_STALL = 2;
  localparam int FLAW_REARM = 3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // line
  logic              in_tuser = 1'b0; // kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;       // status[2:0], receiving, frame_data
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  edge_timing_scoreboard sb;
  int sender_idle;
  int receiver_idle;
  bit hold_req = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent_words = 0;
  bit line_eff = 1'b0;

  manchester_edge_timing_receiver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL manchester_edge_timing_receiver_unit");
      $finish;
    end
  end

  // result side, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = $urandom_range(150, 300);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  task automatic set_mode(int m);
    case (m)
      MODE_RX_SLOW: begin sender_idle = 8;  receiver_idle = 69; end
      MODE_TX_SLOW: begin sender_idle = 69; receiver_idle = 8;  end
      default:      begin sender_idle = 0;  receiver_idle = 0;  end
    endcase
  endtask

  task automatic send_word(logic k, logic l);
    set_mode(sent_words < ITEMS / 3 ? MODE_RX_SLOW :
             (sent_words < (2 * ITEMS) / 3 ? MODE_TX_SLOW : MODE_NO_IDLE));
    while ($urandom_range(0, 99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {7'b0, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(k, l);
    sent_words++;
    @(negedge clk);
  endtask

  // registers change only once every result word has been taken
  task automatic set_reg(logic [ADDR_W-1:0] a, int v);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    sb.write_reg(a, v[CFG_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int p, int t, bit inv);
    set_reg(REG_BIT_PERIOD, p);
    set_reg(REG_TIMEOUT, t);
    set_reg(REG_INVERT, int'(inv));
  endtask

  task automatic tick(bit eff);
    send_word(KIND_TICK, eff ^ sb.inv);
    line_eff = eff;
  endtask

  task automatic arm(bit eff);
    send_word(KIND_ARM, eff ^ sb.inv);
    line_eff = eff;
  endtask

  task automatic hold(int n);
    repeat (n) tick(line_eff);
  endtask

  // next edge lands g ticks after the previous one
  task automatic gap(int g);
    hold(g - 1);
    tick(!line_eff);
  endtask

  function automatic int half_gap();
    int p;
    int lo;
    int mid;
    p = sb.period;
    lo = p / 3;
    mid = (p * 2) / 3;
    if (lo + 1 <= mid - 1) return $urandom_range(lo + 1, mid - 1);
    return mid;
  endfunction

  function automatic int full_gap();
    int p;
    int mid;
    int hi;
    p = sb.period;
    mid = (p * 2) / 3;
    hi = (p * 4) / 3;
    if (mid + 1 <= hi - 1) return $urandom_range(mid + 1, hi - 1);
    return hi;
  endfunction

  task automatic frame(int flaw);
    int bad_at;
    bit start_low;
    bad_at = (flaw != FLAW_NONE) ? $urandom_range(1, FRAME_BITS - 1) : -1;
    start_low = ($urandom_range(0, 3) == 0);
    arm(!start_low);
    if (start_low) tick(1'b1);
    hold($urandom_range(0, 3));
    tick(1'b0);
    gap(half_gap());
    for (int i = 1; i < FRAME_BITS; i++) begin
      if (i == bad_at) begin
        case (flaw)
          FLAW_GAP: gap($urandom_range(1, (sb.period * 4) / 3 + 3));
          FLAW_STALL: begin
            hold(sb.tmo + 2);
            return;
          end
          default: arm(line_eff);
        endcase
      end
      if ($urandom_range(0, 1)) begin
        gap(full_gap());
      end else begin
        gap(half_gap());
        gap(half_gap());
      end
    end
    hold($urandom_range(1, 3));
  endtask

  task automatic new_setting();
    int p;
    int hi;
    int t;
    p = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 4) : $urandom_range(5, 12);
    hi = (p * 4) / 3;
    t = ($urandom_range(0, 4) == 0) ? $urandom_range(1, hi) : hi + $urandom_range(0, 20);
    setup(p, t, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int r;
    sb = new();
    set_mode(MODE_RX_SLOW);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle ticks before any arm are ignored
    tick(1'b0);
    tick(1'b1);
    tick(1'b0);

    // reset defaults: an early edge has bad timing
    arm(1'b1);
    tick(1'b0);
    hold(3);
    gap(5);
    hold(2);

    // clean frames, both line polarities
    setup(5, 6, 0);
    frame(FLAW_NONE);
    hold_req = 1;
    frame(FLAW_NONE);
    set_reg(REG_INVERT, 1);
    frame(FLAW_NONE);
    set_reg(REG_INVERT, 0);

    // full gap where a half gap is due, then edges outside both windows
    arm(1'b1);
    tick(1'b0);
    gap(4);
    arm(1'b1);
    tick(1'b0);
    gap(1);
    arm(1'b1);
    tick(1'b0);
    gap(3);

    // rearm during a frame restarts reception
    arm(1'b1);
    tick(1'b0);
    gap(2);
    arm(1'b1);
    frame(FLAW_NONE);

    // edge on the timeout tick is classed, then timeout
    set_reg(REG_TIMEOUT, 2);
    arm(1'b1);
    tick(1'b0);
    gap(2);
    hold(3);

    // shortest timeout
    set_reg(REG_TIMEOUT, 1);
    arm(1'b1);
    tick(1'b0);
    hold(2);

    // shortest bit period: no half window at all
    setup(3, 10, 1);
    arm(1'b1);
    tick(1'b0);
    gap(3);
    arm(1'b1);
    tick(1'b0);
    gap(2);

    // longest bit period and timeout
    setup(32767, 65535, 0);
    arm(1'b1);
    tick(1'b0);
    gap(5);
    set_reg(REG_TIMEOUT, 3);
    arm(1'b1);
    tick(1'b0);
    hold(4);

    // random part
    hold_req = 1;
    new_setting();
    while (sent_words < ITEMS) begin
      if ($urandom_range(0, 3) == 0) new_setting();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        frame(FLAW_NONE);
      end else if (r < 70) begin
        frame(FLAW_GAP);
      end else if (r < 80) begin
        frame(FLAW_STALL);
      end else if (r < 88) begin
        frame(FLAW_REARM);
      end else begin
        repeat ($urandom_range(4, 12)) begin
          send_word($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
          line_eff = in_tdata[0] ^ sb.inv;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS manchester_edge_timing_receiver_unit");
    end else begin
      $display("FAIL manchester_edge_timing_receiver_unit");
    end
    $finish;
  end
endmodule
